/* sv/tedc_pkg.sv */
// ----------------------------------------------------------------------------
// tedc_pkg
// Shared codes and constants for the tensor element down-converter.
// ----------------------------------------------------------------------------
package tedc_pkg;

    // configuration register indexes
    localparam logic REG_SOURCE_FORMAT = 1'b0;
    localparam logic REG_TARGET_FORMAT = 1'b1;

    // source format codes
    localparam logic [3:0] SRC_F64  = 4'd0;
    localparam logic [3:0] SRC_F32  = 4'd1;
    localparam logic [3:0] SRC_F16  = 4'd2;
    localparam logic [3:0] SRC_BF16 = 4'd3;
    localparam logic [3:0] SRC_I64  = 4'd4;
    localparam logic [3:0] SRC_I32  = 4'd5;
    localparam logic [3:0] SRC_I16  = 4'd6;
    localparam logic [3:0] SRC_I8   = 4'd7;
    localparam logic [3:0] SRC_U8   = 4'd8;

    // target / result format codes
    localparam logic [1:0] TGT_F32  = 2'd0;
    localparam logic [1:0] TGT_F16  = 2'd1;
    localparam logic [1:0] TGT_BF16 = 2'd2;
    localparam logic [1:0] TGT_RSVD = 2'd3;

    localparam logic [30:0] F32_MAX_MAG = 31'h7F7FFFFF;
    localparam logic [30:0] F32_INF_MAG = 31'h7F800000;
    localparam logic [14:0] F16_NAN_MAG = 15'h7E00;
    localparam logic [14:0] F16_INF_MAG = 15'h7C00;
    // significand of the bf16 scale factor 1.001957f (exponent 0)
    localparam logic [23:0] BF16_SCALE_MANT = 24'h804021;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_UNS,
        KIND_DIRECT,
        KIND_ROUND
    } kind_t;

    // per-beat control that rides along every stage
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  tgt;
        logic [1:0]  fmt;
        logic        last;
        logic        sign;
        logic        is_int;
        logic [31:0] direct;
    } ctl_t;

endpackage

/* sv/tensor_element_down_converter.sv */
// ----------------------------------------------------------------------------
// tensor_element_down_converter
// Converts one raw tensor element per beat to f32, f16 or bf16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries element_bits and
//   last_in_tensor. Output channel (out_valid / out_stall) carries
//   result_bits, result_format, unsupported and last_out; one result beat per
//   input beat, in order.
//   source_format and target_format are set through cfg_we / cfg_index /
//   cfg_data while the block is idle.
// Timing:
//   Eight register stages: decode, leading-zero count, normalize, 53-bit
//   rounding (integer to bf16), denormal shift, f32 rounding, f16 convert and
//   bf16 multiply, bf16 rounding into the output register. One beat can
//   enter every cycle while in_stall is low.
// Reset:
//   Pipeline empties, source_format goes to f32 and target_format to f32.
// Stall:
//   A stalled output beat holds in the output register. Empty stages further
//   up keep filling, so in_stall rises only once every stage holds a beat.
// ----------------------------------------------------------------------------
module tensor_element_down_converter
    import tedc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] element_bits,
    input  logic        last_in_tensor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits,
    output logic [1:0]  result_format,
    output logic        unsupported,
    output logic        last_out
);

    localparam int STAGES = 8;

    logic [3:0]        src_reg;
    logic [1:0]        tgt_reg;
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] ready;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= SRC_F32;
            tgt_reg <= TGT_F32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT: src_reg <= cfg_data;
                REG_TARGET_FORMAT: tgt_reg <= cfg_data[1:0];
                default:           src_reg <= src_reg;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // A stage loads when it is empty or the stage below it moves.
    always_comb
    begin
        ready[STAGES-1] = !v_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !v_reg[i] || ready[i+1];
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (ready[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 1: decode ----------------
    ctl_t               c1_next, c1_reg;
    logic [63:0]        mag1_next, mag1_reg;
    logic signed [11:0] e1_next, e1_reg;
    logic [63:0]        ival;
    logic               ival_ok;

    always_comb
    begin
        ival    = element_bits;
        ival_ok = 1'b1;
        case (src_reg)
            SRC_I64: ival = element_bits;
            SRC_I32: ival = {{32{element_bits[31]}}, element_bits[31:0]};
            SRC_I16: ival = {{48{element_bits[15]}}, element_bits[15:0]};
            SRC_I8:  ival = {{56{element_bits[7]}}, element_bits[7:0]};
            SRC_U8:  ival = {56'd0, element_bits[7:0]};
            default: ival_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        c1_next.kind   = KIND_UNS;
        c1_next.tgt    = tgt_reg;
        c1_next.fmt    = tgt_reg;
        c1_next.last   = last_in_tensor;
        c1_next.sign   = 1'b0;
        c1_next.is_int = 1'b0;
        c1_next.direct = '0;
        mag1_next      = '0;
        e1_next        = '0;
        case (src_reg)
            SRC_F16, SRC_BF16:
            begin
                c1_next.kind   = KIND_PASS;
                c1_next.direct = {16'd0, element_bits[15:0]};
                c1_next.fmt    = (src_reg == SRC_F16) ? TGT_F16 : TGT_BF16;
            end
            SRC_F64:
            begin
                c1_next.sign = element_bits[63];
                c1_next.kind = KIND_DIRECT;
                if (element_bits[62:52] == 11'h7FF)
                begin
                    if (element_bits[51:0] != 52'd0)
                    begin
                        // quiet NaN, top fraction bits kept
                        c1_next.direct = {element_bits[63], 9'h1FF, element_bits[50:29]};
                    end
                    else
                    begin
                        c1_next.direct = {element_bits[63],
                            (tgt_reg == TGT_F32) ? F32_MAX_MAG : F32_INF_MAG};
                    end
                end
                else if (element_bits[62:52] == 11'd0)
                begin
                    // f64 denormals are far below the f32 range
                    c1_next.direct = {element_bits[63], 31'd0};
                end
                else
                begin
                    c1_next.kind = KIND_ROUND;
                    mag1_next    = {1'b1, element_bits[51:0], 11'd0};
                    e1_next      = signed'({1'b0, element_bits[62:52]}) - 12'sd1023;
                end
            end
            SRC_F32:
            begin
                c1_next.kind = KIND_DIRECT;
                if (element_bits[30:23] == 8'hFF && element_bits[22:0] != 23'd0)
                begin
                    c1_next.direct = {element_bits[31], 9'h1FF, element_bits[21:0]};
                end
                else if (element_bits[30:0] == F32_INF_MAG && tgt_reg == TGT_F32)
                begin
                    c1_next.direct = {element_bits[31], F32_MAX_MAG};
                end
                else
                begin
                    c1_next.direct = element_bits[31:0];
                end
            end
            default:
            begin
                if (ival_ok)
                begin
                    c1_next.is_int = 1'b1;
                    c1_next.sign   = ival[63];
                    if (ival == 64'd0)
                    begin
                        c1_next.kind = KIND_DIRECT;
                    end
                    else
                    begin
                        c1_next.kind = KIND_ROUND;
                        mag1_next    = ival[63] ? (~ival + 64'd1) : ival;
                    end
                end
            end
        endcase
        if (c1_next.kind != KIND_PASS && c1_next.kind != KIND_UNS && tgt_reg == TGT_RSVD)
        begin
            c1_next.kind = KIND_UNS;
        end
        if (c1_next.kind == KIND_UNS)
        begin
            c1_next.fmt    = TGT_F32;
            c1_next.direct = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            c1_reg   <= c1_next;
            mag1_reg <= mag1_next;
            e1_reg   <= e1_next;
        end
    end

    // ---------------- stage 2: leading zeros ----------------
    ctl_t               c2_reg;
    logic [63:0]        mag2_reg;
    logic signed [11:0] e2_reg;
    logic [5:0]         lz2_next, lz2_reg;

    tedc_lzc64 u_lzc (
        .value (mag1_reg),
        .count (lz2_next)
    );

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            c2_reg   <= c1_reg;
            mag2_reg <= mag1_reg;
            e2_reg   <= e1_reg;
            lz2_reg  <= lz2_next;
        end
    end

    // ---------------- stage 3: normalize ----------------
    ctl_t               c3_reg;
    logic [63:0]        m3_reg;
    logic signed [11:0] e3_reg;

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            c3_reg <= c2_reg;
            m3_reg <= mag2_reg << lz2_reg;
            e3_reg <= c2_reg.is_int ? (12'sd63 - signed'({6'd0, lz2_reg})) : e2_reg;
        end
    end

    // ---------------- stage 4: round to 53 bits (int toward bf16) ----------------
    ctl_t               c4_reg;
    logic [63:0]        m4_next, m4_reg;
    logic signed [11:0] e4_next, e4_reg;
    logic [53:0]        sum53;
    logic               inc53;

    always_comb
    begin
        inc53   = m3_reg[10] && ((|m3_reg[9:0]) || m3_reg[11]);
        sum53   = {1'b0, m3_reg[63:11]} + {53'd0, inc53};
        m4_next = m3_reg;
        e4_next = e3_reg;
        if (c3_reg.is_int && c3_reg.tgt == TGT_BF16)
        begin
            if (sum53[53])
            begin
                m4_next = {1'b1, 63'd0};
                e4_next = e3_reg + 12'sd1;
            end
            else
            begin
                m4_next = {sum53[52:0], 11'd0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            c4_reg <= c3_reg;
            m4_reg <= m4_next;
            e4_reg <= e4_next;
        end
    end

    // ---------------- stage 5: denormal alignment ----------------
    ctl_t               c5_reg;
    logic [63:0]        s5_next, s5_reg;
    logic               lost5_next, lost5_reg;
    logic               norm5_next, norm5_reg;
    logic               ovf5_next, ovf5_reg;
    logic [7:0]         eb5_reg;
    logic signed [11:0] eb;
    logic signed [11:0] dsh;
    logic [6:0]         sh5;

    always_comb
    begin
        eb         = e4_reg + 12'sd127;
        dsh        = 12'sd1 - eb;
        norm5_next = eb > 12'sd0;
        ovf5_next  = eb >= 12'sd255;
        if (norm5_next)
        begin
            sh5 = 7'd0;
        end
        else if (dsh > 12'sd64)
        begin
            sh5 = 7'd64;
        end
        else
        begin
            sh5 = dsh[6:0];
        end
        s5_next    = m4_reg >> sh5;
        lost5_next = |(m4_reg & ~({64{1'b1}} << sh5));
    end

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            c5_reg    <= c4_reg;
            s5_reg    <= s5_next;
            lost5_reg <= lost5_next;
            norm5_reg <= norm5_next;
            ovf5_reg  <= ovf5_next;
            eb5_reg   <= eb[7:0];
        end
    end

    // ---------------- stage 6: round to f32 ----------------
    ctl_t        c6_reg;
    logic [31:0] u6_next, u6_reg;
    logic [30:0] base6, sum6;
    logic        inc6;
    logic        inf6;

    always_comb
    begin
        base6 = norm5_reg ? {eb5_reg, s5_reg[62:40]} : {7'd0, s5_reg[63:40]};
        inc6  = s5_reg[39] && ((|s5_reg[38:0]) || lost5_reg || s5_reg[40]);
        sum6  = base6 + {30'd0, inc6};
        inf6  = ovf5_reg || (sum6[30:23] == 8'hFF);
        if (c5_reg.kind != KIND_ROUND)
        begin
            u6_next = c5_reg.direct;
        end
        else if (inf6)
        begin
            // f32 target from a float source saturates
            u6_next = {c5_reg.sign, (c5_reg.tgt == TGT_F32 && !c5_reg.is_int)
                                    ? F32_MAX_MAG : F32_INF_MAG};
        end
        else
        begin
            u6_next = {c5_reg.sign, sum6};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[5])
        begin
            c6_reg <= c5_reg;
            u6_reg <= u6_next;
        end
    end

    // ---------------- stage 7: f16 convert, bf16 multiply ----------------
    ctl_t              c7_reg;
    logic [31:0]       u7_reg;
    logic [15:0]       h7_next, h7_reg;
    logic [47:0]       p7_reg;
    logic [7:0]        he8;
    logic signed [8:0] eh;
    logic signed [8:0] dh;
    logic [4:0]        shh;
    logic [23:0]       hm, hs;
    logic              hlost;
    logic [14:0]       hbase;
    logic              hg, hst, hlsb;

    always_comb
    begin
        he8   = u6_reg[30:23];
        eh    = signed'({1'b0, he8}) - 9'sd112;
        dh    = 9'sd1 - eh;
        hm    = {1'b1, u6_reg[22:0]};
        shh   = (dh > 9'sd24) ? 5'd25 : dh[4:0];
        hs    = hm >> shh;
        hlost = |(hm & ~({24{1'b1}} << shh));
        if (eh >= 9'sd1)
        begin
            hbase = {eh[4:0], u6_reg[22:13]};
            hg    = u6_reg[12];
            hst   = |u6_reg[11:0];
            hlsb  = u6_reg[13];
        end
        else
        begin
            hbase = {4'd0, hs[23:13]};
            hg    = hs[12];
            hst   = (|hs[11:0]) || hlost;
            hlsb  = hs[13];
        end
        if (he8 == 8'hFF)
        begin
            h7_next = {u6_reg[31], (u6_reg[22:0] != 23'd0) ? F16_NAN_MAG : F16_INF_MAG};
        end
        else if (he8 == 8'd0)
        begin
            h7_next = {u6_reg[31], 15'd0};
        end
        else if (eh >= 9'sd31)
        begin
            h7_next = {u6_reg[31], F16_INF_MAG};
        end
        else
        begin
            h7_next = {u6_reg[31], hbase + {14'd0, hg && (hst || hlsb)}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[6])
        begin
            c7_reg <= c6_reg;
            u7_reg <= u6_reg;
            h7_reg <= h7_next;
            p7_reg <= {he8 != 8'd0, u6_reg[22:0]} * BF16_SCALE_MANT;
        end
    end

    // ---------------- stage 8: bf16 round, output register ----------------
    logic [31:0] bf_f32;
    logic [31:0] bbase, bsum;
    logic        bg, bst, blsb;
    logic [31:0] res_next;
    logic [31:0] res_reg;
    logic [1:0]  fmt_reg;
    logic        uns_reg;
    logic        last_reg;

    always_comb
    begin
        if (u7_reg[30:23] == 8'd0)
        begin
            // denormal input: encoding is linear in the product
            bbase = {8'd0, p7_reg[46:23]};
            bg    = p7_reg[22];
            bst   = |p7_reg[21:0];
            blsb  = p7_reg[23];
        end
        else if (p7_reg[47])
        begin
            bbase = {{1'b0, u7_reg[30:23]} + 9'd1, p7_reg[46:24]};
            bg    = p7_reg[23];
            bst   = |p7_reg[22:0];
            blsb  = p7_reg[24];
        end
        else
        begin
            bbase = {1'b0, u7_reg[30:23], p7_reg[45:23]};
            bg    = p7_reg[22];
            bst   = |p7_reg[21:0];
            blsb  = p7_reg[23];
        end
        bsum = bbase + {31'd0, bg && (bst || blsb)};
        if (u7_reg[30:0] > F32_INF_MAG)
        begin
            bf_f32 = u7_reg;
        end
        else if (u7_reg[30:23] == 8'hFF || bsum[31:23] >= 9'd255)
        begin
            bf_f32 = {u7_reg[31], F32_INF_MAG};
        end
        else
        begin
            bf_f32 = {u7_reg[31], bsum[30:0]};
        end

        case (c7_reg.tgt)
            TGT_F16:  res_next = {16'd0, h7_reg};
            TGT_BF16: res_next = {16'd0, bf_f32[31:16]};
            default:  res_next = u7_reg;
        endcase
        if (c7_reg.kind == KIND_PASS || c7_reg.kind == KIND_UNS)
        begin
            res_next = c7_reg.direct;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[7])
        begin
            res_reg  <= res_next;
            fmt_reg  <= c7_reg.fmt;
            uns_reg  <= (c7_reg.kind == KIND_UNS);
            last_reg <= c7_reg.last;
        end
    end

    assign result_bits   = res_reg;
    assign result_format = fmt_reg;
    assign unsupported   = uns_reg;
    assign last_out      = last_reg;

endmodule

/* sv/tedc_lzc64.sv */
// ----------------------------------------------------------------------------
// tedc_lzc64
// Leading zero count of a 64-bit word (zero input gives 0).
// ----------------------------------------------------------------------------
module tedc_lzc64 (
    input  logic [63:0] value,
    output logic [5:0]  count
);

    always_comb
    begin
        count = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (value[i])
            begin
                count = 6'(63 - i);
            end
        end
    end

endmodule
